// ===== hdl/stli_pkg.sv =====
// Package: payload types, status codes and default parameters of the interpolator
package stli_pkg;

   localparam int DEF_TABLE_DEPTH   = 64;
   localparam int DEF_FRACTION_BITS = 16;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_DUP   = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] point_key;
      logic signed [31:0] point_value;
      logic signed [31:0] query_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
      logic               clamped;
   } rsp_type;

   // Command broadcast from the sequencer to every cell
   typedef struct packed {
      logic               load;      // insert key at the compare boundary
      logic signed [31:0] key;
      logic signed [31:0] value;
   } cell_cmd_type;

endpackage

// ===== hdl/sorted_table_linear_interpolator_core.sv =====
// Top level: sorted breakpoint table as a chain of cells with an interpolation sequencer
//
// Piecewise linear lookup table. Each req_ beat carries a mode: a load inserts one
// breakpoint (key, value) in ascending key order, a query returns the value at
// query_time, interpolated between neighboring breakpoints or clamped to an end.
// Each request yields exactly one rsp_ beat.
// The table is a chain of TABLE_DEPTH cells; every cell compares its key with the
// broadcast key in parallel and a load shifts the upper part of the chain by one.
// A load passes through the compare, select and output states; a query that does
// not interpolate also passes the neighbor state. An interpolating query adds the
// divide, multiply and add states, the divide state waiting for the
// one-bit-per-cycle divider to finish the fraction.
// One request is in work at a time; req_stall is high from acceptance until its
// result has moved into the output register, so with no stall the next request can
// be taken as soon as the previous rsp_valid rises. A stalled rsp_ beat holds its
// payload until taken, and the next result waits behind it.
// Reset (synchronous, active high) empties the table at once: no clearing pass.
module sorted_table_linear_interpolator_core
   import stli_pkg::*;
#(
   parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int DW = 32 + FRACTION_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CMP    = 3'd1;
   localparam logic [2:0] ST_SEL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_ADD    = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;
   localparam logic [2:0] ST_NBR    = 3'd7;

   logic [2:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cell_cmd_type       cmd;

   logic [TABLE_DEPTH-1:0] c_valid, c_gt, c_eq, p_valid, p_gt, top_vec;
   logic signed [31:0]     c_key [TABLE_DEPTH];
   logic signed [31:0]     c_val [TABLE_DEPTH];
   logic signed [31:0]     p_key [TABLE_DEPTH];
   logic signed [31:0]     p_val [TABLE_DEPTH];

   // Registered compare results and selected neighbors
   logic                   any_eq_ff, full_ff, empty_ff, below_ff, above_ff, last_ff;
   logic signed [31:0]     klo_ff, khi_ff, vlo_ff, vhi_ff, vlast_ff, vfirst_ff;
   logic [TABLE_DEPTH-1:0] le_vec_ff;

   logic               div_start, div_done;
   logic [DW-1:0]      div_numer, div_denom, div_quot;
   logic [FRACTION_BITS-1:0] frac_ff;
   logic [32:0]        dv_mag_ff;
   logic               dv_neg_ff;
   logic [32+FRACTION_BITS:0] prod_ff;
   logic [IW-1:0]      lo_idx;

   assign cmd.load  = (state_ff == ST_SEL) && (req_ff.mode == MODE_LOAD)
                      && !any_eq_ff && !full_ff;
   assign cmd.key   = (req_ff.mode == MODE_LOAD) ? req_ff.point_key : req_ff.query_time;
   assign cmd.value = req_ff.point_value;

   // Chain of cells, each fed by its lower neighbor
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign p_valid[g] = 1'b1;
         assign p_gt[g]    = 1'b0;
         assign p_key[g]   = '0;
         assign p_val[g]   = '0;
      end else begin : g_rest
         assign p_valid[g] = c_valid[g-1];
         assign p_gt[g]    = c_gt[g-1];
         assign p_key[g]   = c_key[g-1];
         assign p_val[g]   = c_val[g-1];
      end
      stli_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .prev_valid(p_valid[g]), .prev_gt(p_gt[g]),
         .prev_key(p_key[g]), .prev_value(p_val[g]),
         .valid(c_valid[g]), .gt(c_gt[g]), .eq(c_eq[g]),
         .key(c_key[g]), .value(c_val[g])
      );
   end

   // Mark the highest filled cell
   assign top_vec = c_valid & ~(c_valid >> 1);

   // Find the last breakpoint whose key is not above the time (valid, not gt)
   always_comb begin
      lo_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (le_vec_ff[i]) begin
            lo_idx = IW'(i);
         end
      end
   end

   stli_divider #(.WIDTH(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(div_numer), .denom(div_denom), .done(div_done), .quot(div_quot)
   );

   assign div_start = (state_ff == ST_NBR) && !empty_ff
                      && !below_ff && !above_ff && !last_ff;
   assign div_numer = {32'(cmd.key - klo_ff), {FRACTION_BITS{1'b0}}};
   assign div_denom = {{FRACTION_BITS{1'b0}}, 32'(khi_ff - klo_ff)};

   // Sequence one request through compare and select, then divide, multiply and add if it interpolates
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_CMP;
            end
         end
         ST_CMP: state_in = ST_SEL;
         ST_SEL: begin
            res_in = '0;
            if (req_ff.mode == MODE_LOAD) begin
               if (any_eq_ff) res_in.status = STATUS_DUP;
               else if (full_ff) res_in.status = STATUS_FULL;
               state_in = ST_OUT;
            end else begin
               state_in = ST_NBR;
            end
         end
         ST_NBR: begin
            if (empty_ff) begin
               res_in.status = STATUS_EMPTY;
               state_in = ST_OUT;
            end else if (below_ff) begin
               res_in.result_value = vfirst_ff;
               res_in.clamped = 1'b1;
               state_in = ST_OUT;
            end else if (above_ff) begin
               res_in.result_value = vlast_ff;
               res_in.clamped = 1'b1;
               state_in = ST_OUT;
            end else if (last_ff) begin
               res_in.result_value = vlast_ff;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: if (div_done) state_in = ST_MUL;
         ST_MUL: state_in = ST_ADD;
         ST_ADD: begin
            res_in.result_value = dv_neg_ff
               ? 32'(vlo_ff - 32'(prod_ff[32+FRACTION_BITS:FRACTION_BITS]))
               : 32'(vlo_ff + 32'(prod_ff[32+FRACTION_BITS:FRACTION_BITS]));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   // Register compare outcomes of the cell row
   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP) begin
         any_eq_ff <= |c_eq;
         full_ff   <= c_valid[TABLE_DEPTH-1];
         empty_ff  <= !c_valid[0];
         below_ff  <= c_gt[0];
         le_vec_ff <= c_valid & ~c_gt;
         above_ff  <= c_valid[0] && !(|c_gt) && !(|(c_eq & top_vec));
         last_ff   <= |(c_eq & top_vec);
      end
   end

   // Select the neighbors combinationally from the registered compare vector
   logic               lo_top;
   logic signed [31:0] klast_c, vlast_c;
   always_comb begin
      lo_top  = (lo_idx == IW'(TABLE_DEPTH - 1)) || !c_valid[lo_idx + IW'(1)];
      klast_c = c_key[lo_idx];
      vlast_c = c_val[lo_idx];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP) begin
         vfirst_ff <= c_val[0];
      end
      if (state_ff == ST_DIV && div_done) begin
         frac_ff <= div_quot[FRACTION_BITS-1:0];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= (FRACTION_BITS+33)'(dv_mag_ff)
                    * (FRACTION_BITS+33)'(frac_ff)
                    + (dv_neg_ff ? (FRACTION_BITS+33)'((1 << FRACTION_BITS) - 1)
                                 : (FRACTION_BITS+33)'(0));
      end
   end

   // Resolve neighbors in an extra select pass using the registered vector
   logic               sel_pass_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_pass_ff <= 1'b0;
      end else begin
         sel_pass_ff <= (state_ff == ST_CMP);
      end
      if (sel_pass_ff) begin
         klo_ff   <= klast_c;
         vlo_ff   <= vlast_c;
         khi_ff   <= lo_top ? klast_c : c_key[lo_idx + IW'(1)];
         vhi_ff   <= lo_top ? vlast_c : c_val[lo_idx + IW'(1)];
         vlast_ff <= vlast_c;
      end
   end

   logic signed [32:0] dv_w;
   assign dv_w = 33'(vhi_ff) - 33'(vlo_ff);
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         dv_neg_ff <= dv_w[32];
         dv_mag_ff <= dv_w[32] ? 33'(-dv_w) : 33'(dv_w);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CMP))
      else $error("accepted request did not start compare");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("stalled result changed");
   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      c_valid[TABLE_DEPTH-1] |-> c_valid[0])
      else $error("table cells not contiguous");
   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");
`endif

endmodule

// ===== hdl/stli_cell.sv =====
// One table cell: holds one breakpoint, compares it and shifts toward the upper neighbor
module stli_cell
   import stli_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_cmd_type       cmd,
   input  logic               prev_valid,    // lower neighbor holds a point (high below cell 0)
   input  logic               prev_gt,       // lower neighbor key is above cmd.key
   input  logic signed [31:0] prev_key,
   input  logic signed [31:0] prev_value,
   output logic               valid,
   output logic               gt,            // this key is above cmd.key
   output logic               eq,
   output logic signed [31:0] key,
   output logic signed [31:0] value
);

   logic               valid_ff, valid_in;
   logic signed [31:0] key_ff, key_in;
   logic signed [31:0] value_ff, value_in;
   logic               own_gt;

   assign own_gt = valid_ff && (key_ff > cmd.key);
   assign gt     = own_gt;
   assign eq     = valid_ff && (key_ff == cmd.key);

   // Shift up when at or above the insert point, take the new point at the boundary
   // or in the first empty cell
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.load) begin
         if (prev_gt) begin
            valid_in = prev_valid;
            key_in   = prev_key;
            value_in = prev_value;
         end else if (own_gt || (!valid_ff && prev_valid)) begin
            valid_in = 1'b1;
            key_in   = cmd.key;
            value_in = cmd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;

endmodule

// ===== hdl/stli_divider.sv =====
// Restoring divider: one quotient bit a cycle, unsigned
module stli_divider
   import stli_pkg::*;
#(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] numer,
   input  logic [WIDTH-1:0] denom,
   output logic             done,
   output logic [WIDTH-1:0] quot
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quot_ff, quot_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   assign trial = {rem_ff[WIDTH-1:0], quot_ff[WIDTH-1]};

   // Shift in one numerator bit, subtract when it fits
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== tb/sorted_table_linear_interpolator_checker.sv =====
// Checker: predicts interpolator results from the observed request beats and compares
`timescale 1ns / 100ps
module sorted_table_linear_interpolator_checker
   import stli_pkg::*;
#(
   parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count,
   output int      table_fill,
   output int      rsp_total
);

   logic signed [31:0] keys [TABLE_DEPTH];
   logic signed [31:0] vals [TABLE_DEPTH];
   int                 fill;
   rsp_type            expected_rsps [$];

   assign table_fill    = fill;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Piecewise interpolation between entries lo and lo+1, floored
   function automatic logic signed [31:0] interp_at(input int lo, input longint t);
      longint  num, den, dv, step;
      longint unsigned frac, mag, one;
      num  = t - longint'(keys[lo]);
      den  = longint'(keys[lo+1]) - longint'(keys[lo]);
      frac = (unsigned'(num) << FRACTION_BITS) / unsigned'(den);
      dv   = longint'(vals[lo+1]) - longint'(vals[lo]);
      one  = 64'd1 << FRACTION_BITS;
      mag  = unsigned'(dv < 0 ? -dv : dv) * frac;
      if (dv < 0) step = -longint'((mag + one - 1) >> FRACTION_BITS);
      else step = longint'(mag >> FRACTION_BITS);
      return 32'(longint'(vals[lo]) + step);
   endfunction

   // Apply one request beat to the shadow table, return the expected result
   function automatic rsp_type predict_lookup(input req_type r);
      rsp_type o;
      int      pos, lo;
      bit      dup;
      longint  t;
      o = '0;
      if (r.mode == MODE_LOAD) begin
         pos = fill;
         dup = 0;
         for (int i = 0; i < fill; i++) begin
            if (keys[i] == r.point_key) begin
               dup = 1;
               break;
            end
            if (keys[i] > r.point_key) begin
               pos = i;
               break;
            end
         end
         if (dup) o.status = STATUS_DUP;
         else if (fill >= TABLE_DEPTH) o.status = STATUS_FULL;
         else begin
            for (int i = fill; i > pos; i--) begin
               keys[i] = keys[i-1];
               vals[i] = vals[i-1];
            end
            keys[pos] = r.point_key;
            vals[pos] = r.point_value;
            fill++;
         end
      end else begin
         t = r.query_time;
         if (fill == 0) o.status = STATUS_EMPTY;
         else if (t < keys[0]) begin
            o.result_value = vals[0];
            o.clamped = 1'b1;
         end else if (t > keys[fill-1]) begin
            o.result_value = vals[fill-1];
            o.clamped = 1'b1;
         end else if (t == keys[fill-1]) o.result_value = vals[fill-1];
         else begin
            lo = 0;
            for (int i = 0; i + 1 < fill; i++)
               if (keys[i+1] > t) begin
                  lo = i;
                  break;
               end
            o.result_value = interp_at(lo, t);
         end
      end
      return o;
   endfunction

   // Predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fill <= 0;
         error_count <= 0;
         rsp_total <= 0;
         pending_count <= 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(predict_lookup(req_data));
         if (rsp_valid && !rsp_stall) begin
            rsp_total <= rsp_total + 1;
            if (expected_rsps.size() == 0) report_mismatch("unexpected beat", 1, 0);
            else begin
               want = expected_rsps.pop_front();
               if (rsp_data.result_value !== want.result_value)
                  report_mismatch("result_value", rsp_data.result_value, want.result_value);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.clamped !== want.clamped)
                  report_mismatch("clamped", rsp_data.clamped, want.clamped);
            end
         end
         pending_count <= expected_rsps.size();
      end
   end

endmodule

// ===== tb/sorted_table_linear_interpolator_core_test.sv =====
// Testbench top: stimulus, idling phases and verdict for the interpolator
`timescale 1ns / 100ps
module sorted_table_linear_interpolator_core_test;
   import stli_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      error_count, pending_count, table_fill, rsp_total;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      hold_off_cycles = 0;
   int      beats_sent = 0;

   sorted_table_linear_interpolator_core u_top (.*);

   sorted_table_linear_interpolator_checker u_check (.*);

   always #10 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Drive result stall: a long hold-off when asked, otherwise random
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed(32'($urandom_range(40)) << 16) - 32'sd1310720;
         default: return $urandom;
      endcase
   endfunction

   // Offer one beat, hold it until accepted, then drop valid before the next beat
   task automatic send_beat(input logic mode, input logic signed [31:0] k,
                            input logic signed [31:0] v, input logic signed [31:0] t);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1;
      req_data  <= '{mode: mode, point_key: k, point_value: v, query_time: t};
      do @(posedge clock); while (req_stall);
      req_valid <= 0;
      beats_sent++;
      @(posedge clock);
   endtask

   task automatic drain_table();
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic random_beat();
      logic signed [31:0] w;
      w = pick_word();
      if ($urandom_range(9) < 3) send_beat(MODE_LOAD, w, pick_word(), $urandom);
      else send_beat(MODE_QUERY, $urandom, $urandom, w);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty query, extremes, duplicate, clamps, exact last key, interpolation
      send_beat(MODE_QUERY, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
      send_beat(MODE_LOAD, 32'sh8000_0000, 32'sh7fff_ffff, 0);
      send_beat(MODE_QUERY, 0, 0, 32'sh7fff_ffff);
      send_beat(MODE_LOAD, 32'sh7fff_ffff, 32'sh8000_0000, 0);
      send_beat(MODE_LOAD, 32'sh7fff_ffff, 32'sh0000_1234, 32'hffff_ffff);
      send_beat(MODE_QUERY, 0, 0, 32'sh7fff_ffff);
      send_beat(MODE_QUERY, 0, 0, 32'sh8000_0000);
      send_beat(MODE_QUERY, 0, 0, 0);
      send_beat(MODE_QUERY, 0, 0, 32'sh7fff_fffe);
      send_beat(MODE_QUERY, 0, 0, 32'sh8000_0001);
      send_beat(MODE_LOAD, 32'sh0001_0000, 32'sh0005_8000, 0);
      send_beat(MODE_LOAD, 32'sh0003_0000, -32'sh0002_0000, 0);
      send_beat(MODE_QUERY, 0, 0, 32'sh0002_0000);
      send_beat(MODE_QUERY, 0, 0, 32'sh0002_5555);
      send_beat(MODE_QUERY, 0, 0, 32'sh0001_0000);
      drain_table();

      // Fill the table to overflow, starting with results held off
      hold_off_cycles <= 300;
      while (table_fill < DEF_TABLE_DEPTH)
         send_beat(MODE_LOAD, $urandom, $urandom, 0);
      send_beat(MODE_LOAD, $urandom, $urandom, 0);
      send_beat(MODE_LOAD, 32'sh7fff_ffff, 0, 0);
      drain_table();

      // Random phases across idling mixes; the full table carries over between them
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 86 : (ph == 3 ? 28 : 0);
         stall_pct     = (ph == 2) ? 86 : (ph == 3 ? 28 : 0);
         if (ph == 3) send_idle_pct = 28;
         repeat (85) random_beat();
         drain_table();
      end

      repeat (80) @(posedge clock);
      $display("covered %0d request beats, %0d result beats, table fill %0d at end",
               beats_sent, rsp_total, table_fill);
      $display("loads, duplicates, overflow, empty and clamped queries, interpolation");
      if (error_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
